// ----- sv/uwbfp_pkg.sv -----
`timescale 1ns / 1ps
package uwbfp_pkg;

	localparam int ANCHOR_SLOTS = 8;
	localparam int SLOT_W       = (ANCHOR_SLOTS > 1) ? $clog2(ANCHOR_SLOTS) : 1;

	localparam logic [7:0] SYNC1_BYTE    = 8'h57;
	localparam logic [7:0] SYNC2_BYTE    = 8'h58;
	localparam logic [7:0] POS_TYPE1     = 8'h40;
	localparam logic [7:0] POS_TYPE2     = 8'h0C;
	localparam logic [7:0] ANC_TYPE1     = 8'h10;
	localparam logic [7:0] ANC_TYPE2     = 8'h20;

	localparam logic [5:0] POS_FRAME_LEN = 6'd18;
	localparam logic [5:0] ANC_FRAME_LEN = 6'd38;
	localparam logic [5:0] POS_SUM_END   = POS_FRAME_LEN - 6'd2;
	localparam logic [5:0] ANC_SUM_END   = ANC_FRAME_LEN - 6'd2;
	localparam logic [5:0] BODY_FIRST    = 6'd4;

	localparam logic [5:0] POS_FIELD_FIRST = 6'd8;
	localparam logic [5:0] POS_FIELD_LAST  = 6'd13;
	localparam logic [5:0] ANC_ID_LO       = 6'd14;
	localparam logic [5:0] ANC_ID_HI       = 6'd15;
	localparam logic [5:0] ANC_RANGE_LO    = 6'd22;
	localparam logic [5:0] ANC_RANGE_HI    = 6'd23;

	localparam logic [15:0] MAX_JUMP_RESET = 16'd10;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [1:0] {
		KIND_POS     = 2'd0,
		KIND_ANCHOR  = 2'd1,
		KIND_CHK_ERR = 2'd2,
		KIND_FULL    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SYNC2,
		ST_TYPE1,
		ST_TYPE2,
		ST_BODY,
		ST_CHECK,
		ST_JUMP
	} state_t;

	typedef struct packed {
		logic set_kind;
		logic kind_anchor;
		logic start_frame;
		logic body_sum;
		logic body_low;
		logic body_hi;
		logic load_sq;
		logic emit_err;
		logic emit_pos;
		logic emit_anc;
	} cmd_t;

	typedef struct packed {
		logic is_sync1;
		logic is_sync2;
		logic is_pos_type1;
		logic is_pos_type2;
		logic is_anc_type1;
		logic is_anc_type2;
		logic anchor;
		logic sum_byte;
		logic low_byte;
		logic chk_ok;
	} status_t;

	function automatic logic [2:0] slot_out(slot_t s);
		return 3'(s);
	endfunction

endpackage

// ----- sv/uwbfp_if.sv -----
`timescale 1ns / 1ps
interface uwbfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, rx_byte, input ready);
	modport sink(input valid, rx_byte, output ready);
endinterface

interface uwbfp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] pos_x_cm;
	logic signed [15:0] pos_y_cm;
	logic signed [15:0] pos_z_cm;
	logic               jump_ok;
	logic [2:0]         anchor_slot;
	logic [15:0]        anchor_ident;
	logic signed [15:0] anchor_range_cm;

	modport source(output valid, kind, pos_x_cm, pos_y_cm, pos_z_cm, jump_ok,
		anchor_slot, anchor_ident, anchor_range_cm, input ready);
	modport sink(input valid, kind, pos_x_cm, pos_y_cm, pos_z_cm, jump_ok,
		anchor_slot, anchor_ident, anchor_range_cm, output ready);
endinterface

// ----- sv/uwbfp_ctrl.sv -----
`timescale 1ns / 1ps
module uwbfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  uwbfp_pkg::status_t st,
	output uwbfp_pkg::cmd_t   cmd
);
	import uwbfp_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;
	logic   restart_sync;

	assign in_ready     = (state_q != ST_CHECK) && (state_q != ST_JUMP);
	assign accept       = in_valid && in_ready;
	assign out_free     = !out_valid_q || out_ready;
	assign restart_sync = st.is_sync1;
	assign out_valid    = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_HUNT: begin
				if (accept) state_nxt = restart_sync ? ST_SYNC2 : ST_HUNT;
			end
			ST_SYNC2: begin
				if (accept) begin
					if (st.is_sync2) state_nxt = ST_TYPE1;
					else state_nxt = restart_sync ? ST_SYNC2 : ST_HUNT;
				end
			end
			ST_TYPE1: begin
				if (accept) begin
					if (st.is_pos_type1 || st.is_anc_type1) state_nxt = ST_TYPE2;
					else state_nxt = restart_sync ? ST_SYNC2 : ST_HUNT;
				end
			end
			ST_TYPE2: begin
				if (accept) begin
					if (st.anchor ? st.is_anc_type2 : st.is_pos_type2) state_nxt = ST_BODY;
					else state_nxt = restart_sync ? ST_SYNC2 : ST_HUNT;
				end
			end
			ST_BODY: begin
				if (accept && !st.sum_byte && !st.low_byte) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (st.chk_ok && !st.anchor) state_nxt = ST_JUMP;
				else if (out_free) state_nxt = ST_HUNT;
			end
			ST_JUMP: begin
				if (out_free) state_nxt = ST_HUNT;
			end
			default: state_nxt = ST_HUNT;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_HUNT, ST_SYNC2: ;
			ST_TYPE1: begin
				cmd.set_kind    = accept && (st.is_pos_type1 || st.is_anc_type1);
				cmd.kind_anchor = st.is_anc_type1;
			end
			ST_TYPE2: begin
				cmd.start_frame = accept && (st.anchor ? st.is_anc_type2 : st.is_pos_type2);
			end
			ST_BODY: begin
				cmd.body_sum = accept && st.sum_byte;
				cmd.body_low = accept && st.low_byte;
				cmd.body_hi  = accept && !st.sum_byte && !st.low_byte;
			end
			ST_CHECK: begin
				cmd.load_sq  = st.chk_ok && !st.anchor;
				cmd.emit_err = out_free && !st.chk_ok;
				cmd.emit_anc = out_free && st.chk_ok && st.anchor;
			end
			ST_JUMP: begin
				cmd.emit_pos = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_HUNT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit_err || cmd.emit_pos || cmd.emit_anc) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- sv/uwbfp_dp.sv -----
`timescale 1ns / 1ps
module uwbfp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  uwbfp_pkg::cmd_t    cmd,
	output uwbfp_pkg::status_t st,
	output logic [1:0]         kind,
	output logic signed [15:0] pos_x_cm,
	output logic signed [15:0] pos_y_cm,
	output logic signed [15:0] pos_z_cm,
	output logic               jump_ok,
	output logic [2:0]         anchor_slot,
	output logic [15:0]        anchor_ident,
	output logic signed [15:0] anchor_range_cm
);
	import uwbfp_pkg::*;

	logic        anchor_q;
	logic [5:0]  idx_q;
	logic [15:0] sum_q;
	logic [7:0]  sum_lo_q;
	logic [7:0]  chk_hi_q;
	logic [15:0] hold_q [3];
	logic [15:0] prev_x_q;
	logic [15:0] prev_y_q;
	logic        seen_q;
	logic [15:0] ids_q [ANCHOR_SLOTS];
	logic [15:0] max_jump_q;

	logic [31:0] dx_sq_q;
	logic [31:0] dy_sq_q;
	logic [31:0] thr_sq_q;

	logic [1:0]         kind_q;
	logic signed [15:0] px_q, py_q, pz_q, range_q;
	logic               jump_q;
	logic [2:0]         slot_q;
	logic [15:0]        ident_q;

	logic [5:0]         sum_end;
	logic [5:0]         pos_off;
	logic [2:0]         hold_we;
	logic [15:0]        start_sum;
	logic signed [16:0] dx, dy;
	logic signed [33:0] dx_sq, dy_sq;
	logic [31:0]        thr_sq;
	logic [32:0]        dist_sq;
	logic               jump_now;
	logic               hit;
	slot_t              hit_slot;

	assign sum_end = anchor_q ? ANC_SUM_END : POS_SUM_END;
	assign pos_off = idx_q - POS_FIELD_FIRST;

	assign st.is_sync1     = (rx_byte == SYNC1_BYTE);
	assign st.is_sync2     = (rx_byte == SYNC2_BYTE);
	assign st.is_pos_type1 = (rx_byte == POS_TYPE1);
	assign st.is_pos_type2 = (rx_byte == POS_TYPE2);
	assign st.is_anc_type1 = (rx_byte == ANC_TYPE1);
	assign st.is_anc_type2 = (rx_byte == ANC_TYPE2);
	assign st.anchor       = anchor_q;
	assign st.sum_byte     = (idx_q < sum_end);
	assign st.low_byte     = (idx_q == sum_end);
	assign st.chk_ok       = ({chk_hi_q, sum_lo_q} == sum_q);

	always_comb begin
		hold_we = 3'b000;
		if (cmd.body_sum) begin
			if (!anchor_q) begin
				if (idx_q >= POS_FIELD_FIRST && idx_q <= POS_FIELD_LAST) begin
					unique case (pos_off[2:1])
						2'd0:    hold_we = 3'b001;
						2'd1:    hold_we = 3'b010;
						default: hold_we = 3'b100;
					endcase
				end
			end else if (idx_q == ANC_ID_LO || idx_q == ANC_ID_HI) begin
				hold_we = 3'b001;
			end else if (idx_q == ANC_RANGE_LO || idx_q == ANC_RANGE_HI) begin
				hold_we = 3'b010;
			end
		end
	end

	assign start_sum = 16'(SYNC1_BYTE) + 16'(SYNC2_BYTE)
		+ (anchor_q ? 16'(ANC_TYPE1) : 16'(POS_TYPE1)) + 16'(rx_byte);

	assign dx     = {hold_q[0][15], hold_q[0]} - {prev_x_q[15], prev_x_q};
	assign dy     = {hold_q[1][15], hold_q[1]} - {prev_y_q[15], prev_y_q};
	assign dx_sq  = dx * dx;
	assign dy_sq  = dy * dy;
	assign thr_sq = max_jump_q * max_jump_q;

	assign dist_sq  = {1'b0, dx_sq_q} + {1'b0, dy_sq_q};
	assign jump_now = seen_q && (dist_sq <= {1'b0, thr_sq_q});

	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int k = 0; k < ANCHOR_SLOTS; k++) begin
			if (!hit && (ids_q[k] == hold_q[0] || ids_q[k] == 16'd0)) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q   <= 1'b0;
			idx_q      <= '0;
			sum_q      <= '0;
			sum_lo_q   <= '0;
			chk_hi_q   <= '0;
			hold_q     <= '{default: '0};
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			seen_q     <= 1'b0;
			ids_q      <= '{default: '0};
			max_jump_q <= MAX_JUMP_RESET;
		end else begin
			if (cfg_wr_en) max_jump_q <= cfg_wr_data;
			if (cmd.set_kind) anchor_q <= cmd.kind_anchor;
			if (cmd.start_frame) begin
				sum_q  <= start_sum;
				idx_q  <= BODY_FIRST;
				hold_q <= '{default: '0};
			end
			if (cmd.body_sum) begin
				sum_q <= sum_q + 16'(rx_byte);
				idx_q <= idx_q + 6'd1;
				for (int h = 0; h < 3; h++) begin
					if (hold_we[h]) begin
						if (idx_q[0]) hold_q[h][15:8] <= rx_byte;
						else hold_q[h][7:0] <= rx_byte;
					end
				end
			end
			if (cmd.body_low) begin
				sum_lo_q <= rx_byte;
				idx_q    <= idx_q + 6'd1;
			end
			if (cmd.body_hi) chk_hi_q <= rx_byte;
			if (cmd.emit_pos) begin
				seen_q   <= 1'b1;
				prev_x_q <= hold_q[0];
				prev_y_q <= hold_q[1];
			end
			if (cmd.emit_anc && hit) ids_q[hit_slot] <= hold_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sq) begin
			dx_sq_q  <= 32'(dx_sq);
			dy_sq_q  <= 32'(dy_sq);
			thr_sq_q <= thr_sq;
		end
		if (cmd.emit_pos) begin
			kind_q  <= KIND_POS;
			px_q    <= hold_q[0];
			py_q    <= hold_q[1];
			pz_q    <= hold_q[2];
			jump_q  <= jump_now;
			slot_q  <= '0;
			ident_q <= '0;
			range_q <= '0;
		end else if (cmd.emit_anc) begin
			kind_q  <= hit ? KIND_ANCHOR : KIND_FULL;
			px_q    <= '0;
			py_q    <= '0;
			pz_q    <= '0;
			jump_q  <= 1'b0;
			slot_q  <= hit ? slot_out(hit_slot) : 3'd0;
			ident_q <= hold_q[0];
			range_q <= hold_q[1];
		end else if (cmd.emit_err) begin
			kind_q  <= KIND_CHK_ERR;
			px_q    <= '0;
			py_q    <= '0;
			pz_q    <= '0;
			jump_q  <= 1'b0;
			slot_q  <= '0;
			ident_q <= '0;
			range_q <= '0;
		end
	end

	assign kind            = kind_q;
	assign pos_x_cm        = px_q;
	assign pos_y_cm        = py_q;
	assign pos_z_cm        = pz_q;
	assign jump_ok         = jump_q;
	assign anchor_slot     = slot_q;
	assign anchor_ident    = ident_q;
	assign anchor_range_cm = range_q;

endmodule

// ----- sv/uwb_frame_parser_top.sv -----
`timescale 1ns / 1ps
// Serial frame parser: takes one byte per cycle while hunting for the 57 58 header and
// through the frame body. After the final checksum byte the input stalls in the check state
// (checksum error or anchor frame: anchor table match in parallel) or in the check state
// and then the jump state (position frame: squaring stage, then sum and compare against
// the squared threshold), and longer if the previous result still sits unread in the
// output register. max_jump_cm must be written only while no frame is in progress; the
// block itself does not enforce this.
module uwb_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	uwbfp_in_if.sink    rx,
	uwbfp_out_if.source res
);
	import uwbfp_pkg::*;

	cmd_t    cmd;
	status_t st;

	uwbfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.st        (st),
		.cmd       (cmd)
	);

	uwbfp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_byte         (rx.rx_byte),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.cmd             (cmd),
		.st              (st),
		.kind            (res.kind),
		.pos_x_cm        (res.pos_x_cm),
		.pos_y_cm        (res.pos_y_cm),
		.pos_z_cm        (res.pos_z_cm),
		.jump_ok         (res.jump_ok),
		.anchor_slot     (res.anchor_slot),
		.anchor_ident    (res.anchor_ident),
		.anchor_range_cm (res.anchor_range_cm)
	);

endmodule

// ----- sv/uwbfp_chk.sv -----
`timescale 1ns / 1ps
module uwbfp_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         kind,
	input logic signed [15:0] pos_x_cm,
	input logic signed [15:0] pos_y_cm,
	input logic signed [15:0] pos_z_cm,
	input logic               jump_ok,
	input logic [2:0]         anchor_slot,
	input logic [15:0]        anchor_ident,
	input logic signed [15:0] anchor_range_cm
);
	import uwbfp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CHK_ERR |-> pos_x_cm == 16'sd0 && pos_y_cm == 16'sd0
		&& pos_z_cm == 16'sd0 && !jump_ok && anchor_slot == 3'd0
		&& anchor_ident == 16'd0 && anchor_range_cm == 16'sd0)
		else $error("checksum error result carries data");

	a_pos_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_POS |-> anchor_slot == 3'd0 && anchor_ident == 16'd0
		&& anchor_range_cm == 16'sd0)
		else $error("position result carries anchor data");

	a_anc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ANCHOR || kind == KIND_FULL) |-> pos_x_cm == 16'sd0
		&& pos_y_cm == 16'sd0 && pos_z_cm == 16'sd0 && !jump_ok)
		else $error("anchor result carries position data");

	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FULL |-> anchor_slot == 3'd0)
		else $error("table full result carries a slot");

endmodule

bind uwb_frame_parser_top uwbfp_chk u_uwbfp_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (res.valid),
	.out_ready       (res.ready),
	.kind            (res.kind),
	.pos_x_cm        (res.pos_x_cm),
	.pos_y_cm        (res.pos_y_cm),
	.pos_z_cm        (res.pos_z_cm),
	.jump_ok         (res.jump_ok),
	.anchor_slot     (res.anchor_slot),
	.anchor_ident    (res.anchor_ident),
	.anchor_range_cm (res.anchor_range_cm)
);
